// File: hdl/pin_change_event_dispatcher_core_defines.svh
// Assertion macros shared by the pin change event dispatcher RTL.
`ifndef PIN_CHANGE_EVENT_DISPATCHER_CORE_DEFINES_SVH
`define PIN_CHANGE_EVENT_DISPATCHER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcd assertion failed");

// Next-cycle implication, disabled during reset.
`define PCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcd assertion failed");

`endif

// File: hdl/pcd_pkg.sv
// Types and constants of the pin change event dispatcher.
package pcd_pkg;

  localparam int BankW      = 2;
  localparam int LevelsW    = 8;
  localparam int EnableW    = 24;
  localparam int PinNumW    = 5;

  localparam int BankCountDefault   = 3;
  localparam int PinsPerBankDefault = 8;

  typedef struct packed {
    logic [BankW-1:0]   bank;
    logic [LevelsW-1:0] pin_levels;
  } sample_t;

  typedef struct packed {
    logic [PinNumW-1:0] pin_number;
    logic               new_level;
    logic               last_event;
  } event_t;

  typedef struct packed {
    logic [EnableW-1:0] enable_mask;
  } cfg_t;

endpackage

// File: hdl/pcd_chan_if.sv
// Valid/ready channel carrying one beat of a typed payload.
interface pcd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/pin_change_event_dispatcher_core.sv
// Top level of the pin change event dispatcher: edge detect and event scan.
//
// Usage
//   samples : sink channel, one beat = {bank, pin_levels} of one pin bank.
//   events  : source channel, one beat per changed, enabled pin, lowest pin
//             first; last_event marks the final beat caused by a sample.
//   cfg     : write channel for enable_mask (one bit per global pin); always
//             ready, write it only while the block is idle.
// Timing
//   A sample is taken while the sequencer is idle; a one-bit scan unit then
//   walks the bank's pins one per cycle, unless the event sink stalls on a
//   changed pin, up to the highest changed one, then returns to idle on the
//   emptied vector. samples.ready is high only while the sequencer is idle,
//   so no new sample is taken during a scan. Each event is registered in the
//   event register when the scan reaches its pin and the sink is free.
// Reset and stall
//   rst (synchronous) clears the enables, history and primed flags; the first
//   sample of each bank after reset only primes that bank. When the event
//   sink stalls, hold the event register and freeze the scan on the pending
//   pin; no event is dropped. The event register lets the next sample be
//   taken while the final event still waits.
module pin_change_event_dispatcher_core #(
  parameter int BANK_COUNT    = pcd_pkg::BankCountDefault,
  parameter int PINS_PER_BANK = pcd_pkg::PinsPerBankDefault
) (
  input  logic        clk,
  input  logic        rst,
  pcd_chan_if.sink    samples,
  pcd_chan_if.source  events,
  pcd_chan_if.sink    cfg
);

`include "pin_change_event_dispatcher_core_defines.svh"

  localparam int BankIdxW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam int BankExtW = pcd_pkg::BankW + 2;
  localparam int PinCount = BANK_COUNT * PINS_PER_BANK;

  // Sequencer codes
  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic                          state;
  logic [pcd_pkg::EnableW-1:0]   enable_mask;
  logic [PINS_PER_BANK-1:0]      previous_levels [BANK_COUNT];
  logic [BANK_COUNT-1:0]         bank_primed;

  // Scan unit: remaining changed bits, levels and pin number, shifted in step
  logic [PINS_PER_BANK-1:0]      rest;
  logic [PINS_PER_BANK-1:0]      levels;
  logic [pcd_pkg::PinNumW-1:0]   pin;

  logic                          out_valid;
  pcd_pkg::event_t               out_event;

  logic                          take;
  logic [BankExtW-1:0]           bank_ext;
  logic [BankIdxW-1:0]           bank_idx;
  logic                          bank_ok;
  logic [PINS_PER_BANK-1:0]      curr;
  logic [pcd_pkg::PinNumW-1:0]   pin_base;
  logic [pcd_pkg::EnableW+PINS_PER_BANK-1:0] mask_ext;
  logic [PINS_PER_BANK-1:0]      bank_en;
  logic                          out_free;
  logic                          emit;

  assign cfg.ready     = 1'b1;
  assign samples.ready = (state == StIdle);
  assign take          = samples.valid && samples.ready;

  assign bank_ext = BankExtW'(samples.payload.bank);
  assign bank_idx = bank_ext[BankIdxW-1:0];
  assign bank_ok  = (bank_ext < BankExtW'(BANK_COUNT));
  assign curr     = samples.payload.pin_levels[PINS_PER_BANK-1:0];
  assign pin_base = pcd_pkg::PinNumW'(int'(samples.payload.bank) * PINS_PER_BANK);

  // Pick this bank's enables; pins past the register width read as disabled
  assign mask_ext = {{PINS_PER_BANK{1'b0}}, enable_mask};
  always_comb begin
    logic [pcd_pkg::EnableW+PINS_PER_BANK-1:0] shifted;
    shifted = mask_ext >> pin_base;
    bank_en = shifted[PINS_PER_BANK-1:0];
  end

  assign out_free = !out_valid || events.ready;
  assign emit     = (state == StScan) && rest[0] && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= '0;
    end else if (cfg.valid && cfg.ready) begin
      enable_mask <= cfg.payload.enable_mask;
    end
  end

  // History and primed flags; out-of-range banks leave everything alone
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_primed <= '0;
      for (int b = 0; b < BANK_COUNT; b++) begin
        previous_levels[b] <= '0;
      end
    end else if (take && bank_ok) begin
      bank_primed[bank_idx]     <= 1'b1;
      previous_levels[bank_idx] <= curr;
    end
  end

  // Sequencer and scan unit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      rest  <= '0;
    end else begin
      unique case (state)
        StIdle: begin
          if (take) begin
            state <= StScan;
            // A priming or out-of-range sample leaves nothing to scan
            if (bank_ok && bank_primed[bank_idx]) begin
              rest <= bank_en & (curr ^ previous_levels[bank_idx]);
            end else begin
              rest <= '0;
            end
          end
        end
        StScan: begin
          if (rest == '0) begin
            state <= StIdle;
          end else if (!rest[0] || out_free) begin
            rest <= rest >> 1;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  // Levels and pin number advance with the scan; no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      levels <= curr;
      pin    <= pin_base;
    end else if (state == StScan && rest != '0 && (!rest[0] || out_free)) begin
      levels <= levels >> 1;
      pin    <= pin + pcd_pkg::PinNumW'(1);
    end
  end

  // Event register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_event.pin_number <= pin;
      out_event.new_level  <= levels[0];
      out_event.last_event <= ((rest >> 1) == '0);
    end
  end

  assign events.valid   = out_valid;
  assign events.payload = out_event;

  `PCD_ASSERT_NEXT(a_take_starts_scan, clk, rst, take, state == StScan)
  `PCD_ASSERT_NEXT(a_scan_done_idles, clk, rst, state == StScan && rest == '0, state == StIdle)
  `PCD_ASSERT_NOW(a_pin_in_range, clk, rst, out_valid, int'(out_event.pin_number) < PinCount)

endmodule
